// ----- rtl/core/awf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the anagram window finder.
// No dependencies; imported by every module of the block.

package awf_pkg;

  // Pattern and alphabet limits
  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 26;

  // Field widths
  localparam int LETTER_W = 5;
  localparam int POS_W    = 32;
  localparam int SLOTS    = 2 ** LETTER_W;

  // Pattern length and window fill, 0 .. MAX_PATTERN
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  // Ring index of the recent-letter store
  localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // Running tallies wrap; their difference spans -MAX_PATTERN .. MAX_PATTERN
  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  // Number of letter slots whose tallies differ, 0 .. SLOTS
  localparam int DIFF_W = $clog2(SLOTS + 1);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Input commands
  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // Operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // Item handed from the front stage to the tally stage
  typedef struct packed {
    op_t                 op;
    logic [LETTER_W-1:0] letter;  // letter entering (text) or pattern letter
    logic                win;     // text letter that enters the window
    logic                remove;  // a letter leaves the window
    logic                full;    // window is full after this letter
    logic [POS_W-1:0]    start;   // start index reported for a text letter
  } item_t;

endpackage

// ----- rtl/core/anagram_window_finder.sv -----
`timescale 1ns / 1ps
// Top level of the anagram window finder; instantiates awf_front and
// awf_tally and holds the output register. Uses awf_pkg.
// Pattern letters (command 0) come first, then text letters (command 1);
// every text letter gives one result with a match flag and the start index
// of the current window, and command 2 clears everything. The block takes
// one item per clock cycle while the output is not stalled, set by the single
// write port of each tally memory; a result reaches the output register
// through the hand-off register (ring read) and the tally stage
// registers (tally read), and the tally update is written into it.
// Restart needs no clearing pass: per-letter valid bits drop at once, so
// no clearing pass holds up the items that follow it.

module anagram_window_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [awf_pkg::LETTER_W-1:0]  letter,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          match,
  output logic [awf_pkg::POS_W-1:0]     start_index
);
  import awf_pkg::*;

  logic                s1_valid;
  logic                s1_ready;
  item_t               s1_item;
  logic [LETTER_W-1:0] s1_leave;
  logic                res_valid;
  logic                res_ready;
  logic                res_match;
  logic [POS_W-1:0]    res_start;

  awf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .letter   (letter),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item),
    .s1_leave (s1_leave)
  );

  awf_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item),
    .s1_leave  (s1_leave),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_match (res_match),
    .res_start (res_start)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      match       <= res_match;
      start_index <= res_start;
    end
  end

`ifndef NO_ASSERTIONS
  // Input is refused only when the output register is full and stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused while output can drain");

  // A blocked result stays in the tally stage unchanged
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_start)))
    else $error("blocked result lost or changed");

  // A result taken by the output register shows up on the ports
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=>
      (out_valid && start_index == $past(res_start) && match == $past(res_match)))
    else $error("output register did not load result");
`endif

endmodule

// ----- rtl/core/awf_front.sv -----
`timescale 1ns / 1ps
// Front stage: command decode, length/position/fill control and the ring of
// recent text letters. Depends on awf_pkg.

module awf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [awf_pkg::LETTER_W-1:0]  letter,
  output logic                          s1_valid,
  input  logic                          s1_ready,
  output awf_pkg::item_t                s1_item,
  output logic [awf_pkg::LETTER_W-1:0]  s1_leave
);
  import awf_pkg::*;

  logic                in_fire;
  logic                issue;
  item_t               item_next;

  logic [LEN_W-1:0]    pat_len, pat_len_next;
  logic                started, started_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [RING_W-1:0]   ring_ptr, ring_ptr_next;
  logic [LEN_W-1:0]    fill, fill_next;

  logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
  logic [LETTER_W-1:0] ring_q;
  logic                ring_we;
  logic [RING_W-1:0]   back;

  logic [POS_W:0]      seen;
  logic [POS_W:0]      win_start;
  logic [LEN_W:0]      ptr_ext;
  logic [LEN_W:0]      len_ext;
  logic [LEN_W:0]      back_ext;
  logic [LEN_W-1:0]    fill_inc;
  logic                remove;
  logic                full;

  // Accept whenever the hand-off register is free or moving on
  assign in_ready = !s1_valid || s1_ready;
  assign in_fire  = in_valid && in_ready;

  // Position arithmetic for a text letter
  assign seen      = {1'b0, pos} + (POS_W + 1)'(1);
  assign win_start = seen - (POS_W + 1)'(pat_len);
  assign fill_inc  = fill + LEN_W'(1);
  assign remove    = (fill == pat_len);
  assign full      = remove || (fill_inc == pat_len);

  // Ring slot of the letter that leaves the window
  assign ptr_ext  = (LEN_W + 1)'(ring_ptr);
  assign len_ext  = (LEN_W + 1)'(pat_len);
  assign back_ext = (ptr_ext >= len_ext) ? ptr_ext - len_ext
                                         : ptr_ext + (LEN_W + 1)'(MAX_PATTERN) - len_ext;
  assign back     = back_ext[RING_W-1:0];

  // Decode the command and work out the next control state
  always_comb begin
    issue            = 1'b0;
    ring_we          = 1'b0;
    item_next        = '0;
    item_next.op     = OP_TEXT;
    item_next.letter = letter;
    pat_len_next     = pat_len;
    started_next     = started;
    pos_next         = pos;
    ring_ptr_next    = ring_ptr;
    fill_next        = fill;
    unique case (command)
      CMD_RESTART: begin
        issue         = 1'b1;
        item_next.op  = OP_RESTART;
        pat_len_next  = '0;
        started_next  = 1'b0;
        pos_next      = '0;
        ring_ptr_next = '0;
        fill_next     = '0;
      end
      CMD_PATTERN: begin
        if (!started && pat_len < LEN_W'(MAX_PATTERN) && int'(letter) < ALPHABET) begin
          issue        = 1'b1;
          item_next.op = OP_PATTERN;
          pat_len_next = pat_len + LEN_W'(1);
        end
      end
      CMD_TEXT: begin
        issue        = 1'b1;
        started_next = 1'b1;
        pos_next     = (pos == POS_MAX) ? pos : pos + POS_W'(1);
        if (pat_len == '0) begin
          // empty window starts after the current letter
          item_next.start = seen[POS_W] ? POS_MAX : seen[POS_W-1:0];
        end else begin
          item_next.win    = 1'b1;
          item_next.remove = remove;
          item_next.full   = full;
          item_next.start  = full ? win_start[POS_W-1:0] : '0;
          fill_next        = remove ? fill : fill_inc;
          ring_we          = 1'b1;
          ring_ptr_next    = (ring_ptr == RING_W'(MAX_PATTERN - 1)) ? '0
                                                                   : ring_ptr + RING_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pat_len  <= '0;
      started  <= 1'b0;
      pos      <= '0;
      ring_ptr <= '0;
      fill     <= '0;
    end else begin
      if (in_fire && issue) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
      if (in_fire) begin
        pat_len  <= pat_len_next;
        started  <= started_next;
        pos      <= pos_next;
        ring_ptr <= ring_ptr_next;
        fill     <= fill_next;
      end
    end
  end

  // Hold the item for the tally stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= item_next;
    end
  end

  // Ring of recent letters: read the leaving letter, write the new one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_q <= ring_mem[back];
    end
    if (in_fire && ring_we) begin
      ring_mem[ring_ptr] <= letter;
    end
  end

  assign s1_leave = ring_q;

endmodule

// ----- rtl/core/awf_tally.sv -----
`timescale 1ns / 1ps
// Tally stage: per-letter running tallies in two memories, read-modify-write
// with forwarding, and the count of letters whose tallies differ. Uses awf_pkg.

module awf_tally (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  output logic                          s1_ready,
  input  awf_pkg::item_t                s1_item,
  input  logic [awf_pkg::LETTER_W-1:0]  s1_leave,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_match,
  output logic [awf_pkg::POS_W-1:0]     res_start
);
  import awf_pkg::*;

  // add_mem counts text letters added; sub_mem counts pattern letters plus
  // letters removed. A slot matches when both tallies are equal (mod 2^CNT_W).
  logic [CNT_W-1:0]    add_mem [SLOTS];
  logic [CNT_W-1:0]    sub_mem [SLOTS];
  logic [CNT_W-1:0]    add_in_q, add_out_q, sub_in_q, sub_out_q;
  logic [SLOTS-1:0]    add_vld, sub_vld;

  logic                s1_move;
  logic                s2_valid;
  logic                s2_fire;
  item_t               s2_item;
  logic [LETTER_W-1:0] s2_leave;

  // last write to each memory
  logic                add_wr_v, sub_wr_v;
  logic [LETTER_W-1:0] add_wr_addr, sub_wr_addr;
  logic [CNT_W-1:0]    add_wr_data, sub_wr_data;

  logic [CNT_W-1:0]    add_in, add_out, sub_in, sub_out;
  logic [CNT_W-1:0]    add_in_inc, sub_in_inc, sub_out_inc;
  logic                is_pat, is_win, same;
  logic                in_chg, in_eq_old, in_eq_new;
  logic                out_chg, out_eq_old, out_eq_new;
  logic [1:0]          ups, downs;
  logic [DIFF_W-1:0]   diff, diff_next;

  logic                add_we, sub_we;
  logic [LETTER_W-1:0] add_waddr, sub_waddr;
  logic [CNT_W-1:0]    add_wdata, sub_wdata;

  assign s2_fire  = s2_valid && (s2_item.op != OP_TEXT || res_ready);
  assign s1_ready = !s2_valid || s2_fire;
  assign s1_move  = s1_valid && s1_ready;

  // Resolve each operand: forward the latest write, else memory, else cleared
  always_comb begin
    add_in  = (add_wr_v && add_wr_addr == s2_item.letter) ? add_wr_data :
              (add_vld[s2_item.letter] ? add_in_q : '0);
    add_out = (add_wr_v && add_wr_addr == s2_leave) ? add_wr_data :
              (add_vld[s2_leave] ? add_out_q : '0);
    sub_in  = (sub_wr_v && sub_wr_addr == s2_item.letter) ? sub_wr_data :
              (sub_vld[s2_item.letter] ? sub_in_q : '0);
    sub_out = (sub_wr_v && sub_wr_addr == s2_leave) ? sub_wr_data :
              (sub_vld[s2_leave] ? sub_out_q : '0);
  end

  assign add_in_inc  = add_in + CNT_W'(1);
  assign sub_in_inc  = sub_in + CNT_W'(1);
  assign sub_out_inc = sub_out + CNT_W'(1);

  assign is_pat = (s2_item.op == OP_PATTERN);
  assign is_win = (s2_item.op == OP_TEXT) && s2_item.win;
  // letter leaving equals letter entering: counts stay as they are
  assign same   = s2_item.remove && (s2_leave == s2_item.letter);

  // Slot of the entering (or pattern) letter
  assign in_chg    = is_pat || (is_win && !same);
  assign in_eq_old = (add_in == sub_in);
  assign in_eq_new = is_pat ? (add_in == sub_in_inc) : (add_in_inc == sub_in);

  // Slot of the leaving letter
  assign out_chg    = is_win && s2_item.remove && !same;
  assign out_eq_old = (add_out == sub_out);
  assign out_eq_new = (add_out == sub_out_inc);

  // Update the differing-letter count
  assign ups   = 2'(in_chg && in_eq_old && !in_eq_new) +
                 2'(out_chg && out_eq_old && !out_eq_new);
  assign downs = 2'(in_chg && !in_eq_old && in_eq_new) +
                 2'(out_chg && !out_eq_old && out_eq_new);
  assign diff_next = diff + DIFF_W'(ups) - DIFF_W'(downs);

  // Write-back selection
  assign add_we    = s2_fire && is_win && !same;
  assign add_waddr = s2_item.letter;
  assign add_wdata = add_in_inc;
  assign sub_we    = s2_fire && (is_pat || out_chg);
  assign sub_waddr = is_pat ? s2_item.letter : s2_leave;
  assign sub_wdata = is_pat ? sub_in_inc : sub_out_inc;

  // Result toward the output register
  assign res_valid = s2_valid && (s2_item.op == OP_TEXT);
  assign res_match = s2_item.full && (diff_next == '0);
  assign res_start = s2_item.start;

  // Control state: stage valid, valid bits, difference count
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      diff     <= '0;
      add_vld  <= '0;
      sub_vld  <= '0;
      add_wr_v <= 1'b0;
      sub_wr_v <= 1'b0;
    end else begin
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (s2_fire && s2_item.op == OP_RESTART) begin
        // drop all tallies at once
        diff     <= '0;
        add_vld  <= '0;
        sub_vld  <= '0;
        add_wr_v <= 1'b0;
        sub_wr_v <= 1'b0;
      end else if (s2_fire) begin
        diff <= diff_next;
        if (add_we) begin
          add_vld[add_waddr] <= 1'b1;
          add_wr_v           <= 1'b1;
        end
        if (sub_we) begin
          sub_vld[sub_waddr] <= 1'b1;
          sub_wr_v           <= 1'b1;
        end
      end
    end
  end

  // Stage payload and forwarding registers
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_item  <= s1_item;
      s2_leave <= s1_leave;
    end
    if (add_we) begin
      add_wr_addr <= add_waddr;
      add_wr_data <= add_wdata;
    end
    if (sub_we) begin
      sub_wr_addr <= sub_waddr;
      sub_wr_data <= sub_wdata;
    end
  end

  // Tally memories: two read ports, one write port each
  always_ff @(posedge clk) begin
    if (s1_move) begin
      add_in_q  <= add_mem[s1_item.letter];
      add_out_q <= add_mem[s1_leave];
      sub_in_q  <= sub_mem[s1_item.letter];
      sub_out_q <= sub_mem[s1_leave];
    end
    if (add_we) begin
      add_mem[add_waddr] <= add_wdata;
    end
    if (sub_we) begin
      sub_mem[sub_waddr] <= sub_wdata;
    end
  end

endmodule
